>>> src/mmsr_pkg.sv
// ----------------------------------------------------------------------------
// mmsr_pkg
// Shared types and constants of the staggered minmod reconstruction block.
// ----------------------------------------------------------------------------
package mmsr_pkg;

  localparam int unsigned MaxRowCells = 1024;
  localparam int unsigned ColW        = $clog2(MaxRowCells);
  localparam int unsigned RowW        = 16;
  localparam int unsigned AlphaW      = 18;
  localparam int unsigned CfgIdxW     = 8;
  localparam int unsigned CfgDataW    = 32;
  localparam int unsigned QueueDepth  = 4;
  localparam int unsigned OutDepth    = 8;

  localparam logic [CfgIdxW-1:0] RegInteriorCols = 8'd0;
  localparam logic [CfgIdxW-1:0] RegInteriorRows = 8'd1;
  localparam logic [CfgIdxW-1:0] RegLimiterAlpha = 8'd2;
  localparam logic [CfgIdxW-1:0] RegStaggerParity = 8'd3;

  // One classified input cell travelling from the front to the back.
  typedef struct packed {
    logic signed [31:0] cell_value;
    logic [ColW-1:0]    col;
    logic               do_slope;
    logic               do_emit;
    logic [ColW-1:0]    out_col;
    logic [RowW-1:0]    out_row;
    logic               last;
  } item_t;

  typedef struct packed {
    logic signed [31:0] half_value;
    logic [ColW-1:0]    out_col;
    logic [RowW-1:0]    out_row;
    logic               frame_last;
  } result_t;

endpackage

>>> src/minmod_staggered_reconstruction.sv
// ----------------------------------------------------------------------------
// minmod_staggered_reconstruction
// Minmod-limited staggered reconstruction of one grid plane, Q16.16.
// ----------------------------------------------------------------------------
// Cells of a frame, ghost cells included, enter in raster order on the input
// queue side: a word is taken when push is high and full is low. Each cell
// from column 3 and row 3 on yields one staggered average on the result side,
// shown while empty is low and taken when pop is high. Other cells give none.
// One cell is taken per cycle while full is low; a result then passes the line
// buffer read and the multiply, slope and averaging stages. The value and slope
// line buffers each take one read and one write per cycle, which sets the rate
// of one cell per cycle. A stalled receiver fills the eight-entry result queue;
// the back end then stops draining the four-entry cell queue, and full rises
// once that is full. Registers are written on the always-ready configuration
// channel; the user must write them only while the block is idle, which it
// does not enforce. Any register write restarts the frame. Reset loads the
// register defaults and starts a new frame; line buffers need no clearing.
module minmod_staggered_reconstruction (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [mmsr_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [mmsr_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          push,
  output logic                          full,
  input  logic signed [31:0]            cell_value_i,
  output logic                          empty,
  input  logic                          pop,
  output logic signed [31:0]            half_value_o,
  output logic [mmsr_pkg::ColW-1:0]     out_col_o,
  output logic [mmsr_pkg::RowW-1:0]     out_row_o,
  output logic                          frame_last_o
);
  import mmsr_pkg::*;

  logic              accept, f_valid, q_valid, q_pop;
  item_t             f_item, q_item;
  logic [AlphaW-1:0] alpha;
  result_t           res;

  assign accept = push && !full;

  mmsr_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .push_i      (accept),
    .cell_value_i(cell_value_i),
    .item_valid_o(f_valid),
    .item_o      (f_item),
    .alpha_o     (alpha)
  );

  mmsr_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (f_valid),
    .item_i (f_item),
    .full_o (full),
    .pop_i  (q_pop),
    .valid_o(q_valid),
    .item_o (q_item)
  );

  mmsr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_valid_i(q_valid),
    .item_i      (q_item),
    .item_pop_o  (q_pop),
    .alpha_i     (alpha),
    .empty_o     (empty),
    .pop_i       (pop),
    .result_o    (res)
  );

  assign half_value_o = res.half_value;
  assign out_col_o    = res.out_col;
  assign out_row_o    = res.out_row;
  assign frame_last_o = res.frame_last;

endmodule

>>> src/mmsr_ram.sv
// ----------------------------------------------------------------------------
// mmsr_ram
// Generic one-write, one-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mmsr_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

>>> src/mmsr_front.sv
// ----------------------------------------------------------------------------
// mmsr_front
// Configuration registers, frame position counters and item classification.
// ----------------------------------------------------------------------------
module mmsr_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [mmsr_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [mmsr_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                           push_i,
  input  logic signed [31:0]             cell_value_i,
  output logic                           item_valid_o,
  output mmsr_pkg::item_t                item_o,
  output logic [mmsr_pkg::AlphaW-1:0]    alpha_o
);
  import mmsr_pkg::*;

  logic [ColW-1:0]   cols_q, col_q, col_d;
  logic [RowW-1:0]   rows_q, row_q, row_d;
  logic [AlphaW-1:0] alpha_q;
  logic              parity_q;
  logic [ColW-1:0]   col_end;
  logic [RowW-1:0]   row_end;
  logic              col_last, row_last, cfg_fire;

  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;
  assign alpha_o     = alpha_q;

  // Last column and row index, with the clamped interior size plus ghosts.
  always_comb begin
    if (cols_q == '0) begin
      col_end = ColW'(4);
    end else if (cols_q > ColW'(MaxRowCells - 4)) begin
      col_end = ColW'(MaxRowCells - 1);
    end else begin
      col_end = cols_q + ColW'(3);
    end
    if (rows_q == '0) begin
      row_end = RowW'(4);
    end else if (rows_q > RowW'(65531)) begin
      row_end = RowW'(65534);
    end else begin
      row_end = rows_q + RowW'(3);
    end
  end

  assign col_last = (col_q == col_end);
  assign row_last = (row_q == row_end);

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (cfg_fire) begin
      if (cfg_index_i == RegInteriorCols || cfg_index_i == RegInteriorRows ||
          cfg_index_i == RegLimiterAlpha || cfg_index_i == RegStaggerParity) begin
        col_d = '0;
        row_d = '0;
      end
    end else if (push_i) begin
      if (col_last) begin
        col_d = '0;
        row_d = row_last ? '0 : row_q + RowW'(1);
      end else begin
        col_d = col_q + ColW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q   <= ColW'(256);
      rows_q   <= RowW'(256);
      alpha_q  <= AlphaW'(91750);
      parity_q <= 1'b1;
      col_q    <= '0;
      row_q    <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      if (cfg_fire) begin
        unique case (cfg_index_i)
          RegInteriorCols:  cols_q   <= cfg_data_i[ColW-1:0];
          RegInteriorRows:  rows_q   <= cfg_data_i[RowW-1:0];
          RegLimiterAlpha:  alpha_q  <= cfg_data_i[AlphaW-1:0];
          RegStaggerParity: parity_q <= cfg_data_i[0];
          default: ;
        endcase
      end
    end
  end

  assign item_valid_o      = push_i;
  assign item_o.cell_value = cell_value_i;
  assign item_o.col        = col_q;
  assign item_o.do_slope   = (col_q >= ColW'(2)) && (row_q >= RowW'(2));
  assign item_o.do_emit    = (col_q >= ColW'(3)) && (row_q >= RowW'(3));
  assign item_o.out_col    = parity_q ? col_q - ColW'(2) : col_q - ColW'(1);
  assign item_o.out_row    = parity_q ? row_q - RowW'(2) : row_q - RowW'(1);
  assign item_o.last       = col_last && row_last;

endmodule

>>> src/mmsr_queue.sv
// ----------------------------------------------------------------------------
// mmsr_queue
// Short queue of classified cells between the front and the back.
// ----------------------------------------------------------------------------
module mmsr_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  mmsr_pkg::item_t item_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output mmsr_pkg::item_t item_o
);
  import mmsr_pkg::*;

  localparam int unsigned PtrW = $clog2(QueueDepth);

  item_t           buf_q [QueueDepth];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [PtrW:0]   cnt_q;

  assign full_o  = (cnt_q == (PtrW+1)'(QueueDepth));
  assign valid_o = (cnt_q != '0);
  assign item_o  = buf_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= wptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rptr_q <= rptr_q + PtrW'(1);
      end
      cnt_q <= cnt_q + (PtrW+1)'(push_i) - (PtrW+1)'(pop_i);
    end
  end

endmodule

>>> src/mmsr_back.sv
// ----------------------------------------------------------------------------
// mmsr_back
// Line buffers, slope pipeline, staggered averaging and result queue.
// ----------------------------------------------------------------------------
module mmsr_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        item_valid_i,
  input  mmsr_pkg::item_t             item_i,
  output logic                        item_pop_o,
  input  logic [mmsr_pkg::AlphaW-1:0] alpha_i,
  output logic                        empty_o,
  input  logic                        pop_i,
  output mmsr_pkg::result_t           result_o
);
  import mmsr_pkg::*;

  localparam int unsigned OPtrW = $clog2(OutDepth);

  typedef struct packed {
    logic signed [31:0] v;
    logic signed [31:0] l1;
    logic signed [31:0] l2;
  } col_vals_t;

  function automatic logic signed [31:0] lim_slope(input logic signed [51:0] a,
                                                   input logic signed [51:0] b,
                                                   input logic signed [51:0] c);
    logic signed [51:0] m;
    logic signed [52:0] r;
    logic signed [36:0] s;
    m = '0;
    if (a > 0 && b > 0 && c > 0) begin
      m = (a < b) ? a : b;
      m = (m < c) ? m : c;
    end else if (a < 0 && b < 0 && c < 0) begin
      m = (a > b) ? a : b;
      m = (m > c) ? m : c;
    end
    r = 53'(m) + 53'sd32768;
    s = 37'(r >>> 16);
    if (s > 37'sd2147483647) begin
      return 32'sh7FFFFFFF;
    end else if (s < -37'sd2147483648) begin
      return 32'sh80000000;
    end
    return s[31:0];
  endfunction

  // ---------------- stage 0: issue line buffer reads
  logic            fire0;
  logic [4:0]      inflight;
  logic [OPtrW:0]  ocnt_q;
  logic            v1_q, v2_q, v3_q;
  item_t           it1_q, it2_q, it3_q;

  assign inflight   = 5'(ocnt_q) + 5'(v1_q) + 5'(v2_q) + 5'(v3_q);
  assign fire0      = item_valid_i && (inflight < 5'(OutDepth));
  assign item_pop_o = fire0;

  logic [63:0] vrd, srd;
  logic        swe;
  logic [63:0] swdata;

  // Value line entry holds {row r-2, row r-1} at one column.
  mmsr_ram #(.Width(64), .Depth(MaxRowCells)) u_value_lines (
    .clk_i  (clk_i),
    .we_i   (v1_q),
    .waddr_i(it1_q.col),
    .wdata_i({vrd[31:0], it1_q.cell_value}),
    .re_i   (fire0),
    .raddr_i(item_i.col),
    .rdata_o(vrd)
  );

  // Slope line entry holds {x slope, y slope} of the previous slope row.
  mmsr_ram #(.Width(64), .Depth(MaxRowCells)) u_slope_lines (
    .clk_i  (clk_i),
    .we_i   (swe),
    .waddr_i(it2_q.col - ColW'(1)),
    .wdata_i(swdata),
    .re_i   (fire0),
    .raddr_i(item_i.col - ColW'(1)),
    .rdata_o(srd)
  );

  // ---------------- stage 1: products and value sums
  col_vals_t          cur, p1_q, p2_q;
  logic [63:0]        sp_q;
  logic signed [32:0] dxf, dxc, dxb, dyf, dyc, dyb;
  logic signed [18:0] alpha_s;
  logic signed [51:0] fx_q, cx_q, bx_q, fy_q, cy_q, by_q;
  logic signed [33:0] sumv_q, st_q;

  assign cur.v   = it1_q.cell_value;
  assign cur.l1  = vrd[31:0];
  assign cur.l2  = vrd[63:32];
  assign alpha_s = $signed({1'b0, alpha_i});

  assign dxf = 33'(cur.l1) - 33'(p1_q.l1);
  assign dxc = 33'(cur.l1) - 33'(p2_q.l1);
  assign dxb = 33'(p1_q.l1) - 33'(p2_q.l1);
  assign dyf = 33'(p1_q.v) - 33'(p1_q.l1);
  assign dyc = 33'(p1_q.v) - 33'(p1_q.l2);
  assign dyb = 33'(p1_q.l1) - 33'(p1_q.l2);

  always_ff @(posedge clk_i) begin
    if (v1_q) begin
      p1_q   <= cur;
      p2_q   <= p1_q;
      sp_q   <= srd;
      fx_q   <= 52'(alpha_s * dxf);
      cx_q   <= 52'(dxc) <<< 15;
      bx_q   <= 52'(alpha_s * dxb);
      fy_q   <= 52'(alpha_s * dyf);
      cy_q   <= 52'(dyc) <<< 15;
      by_q   <= 52'(alpha_s * dyb);
      sumv_q <= 34'(p2_q.l2) + 34'(p1_q.l2) + 34'(p2_q.l1) + 34'(p1_q.l1);
      st_q   <= 34'($signed(sp_q[63:32])) - 34'($signed(srd[63:32]))
              + 34'($signed(sp_q[31:0])) + 34'($signed(srd[31:0]));
    end
  end

  // ---------------- stage 2: limited slopes
  logic signed [31:0] xs, ys, xp_q, yp_q;
  logic signed [31:0] xs3_q, ys3_q, xp3_q, yp3_q;
  logic signed [33:0] sumv3_q, st3_q;

  assign xs     = lim_slope(fx_q, cx_q, bx_q);
  assign ys     = lim_slope(fy_q, cy_q, by_q);
  assign swe    = v2_q && it2_q.do_slope;
  assign swdata = {xs, ys};

  always_ff @(posedge clk_i) begin
    if (v2_q) begin
      xp_q    <= xs;
      yp_q    <= ys;
      xs3_q   <= xs;
      ys3_q   <= ys;
      xp3_q   <= xp_q;
      yp3_q   <= yp_q;
      sumv3_q <= sumv_q;
      st3_q   <= st_q;
    end
  end

  // ---------------- stage 3: staggered average
  logic signed [39:0] total;
  logic signed [35:0] avg;
  result_t            res;

  assign total = (40'(sumv3_q) <<< 2) + 40'(st3_q) + 40'(xp3_q) - 40'(xs3_q)
               - 40'(yp3_q) - 40'(ys3_q) + 40'sd8;
  assign avg   = 36'(total >>> 4);

  always_comb begin
    if (avg > 36'sd2147483647) begin
      res.half_value = 32'sh7FFFFFFF;
    end else if (avg < -36'sd2147483648) begin
      res.half_value = 32'sh80000000;
    end else begin
      res.half_value = avg[31:0];
    end
    res.out_col    = it3_q.out_col;
    res.out_row    = it3_q.out_row;
    res.frame_last = it3_q.last;
  end

  // ---------------- result queue
  result_t          obuf_q [OutDepth];
  logic [OPtrW-1:0] owp_q, orp_q;
  logic             opush, opop;

  assign opush    = v3_q && it3_q.do_emit;
  assign empty_o  = (ocnt_q == '0);
  assign opop     = pop_i && !empty_o;
  assign result_o = obuf_q[orp_q];

  always_ff @(posedge clk_i) begin
    if (opush) begin
      obuf_q[owp_q] <= res;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire0) begin
      it1_q <= item_i;
    end
    if (v1_q) begin
      it2_q <= it1_q;
    end
    if (v2_q) begin
      it3_q <= it2_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      owp_q  <= '0;
      orp_q  <= '0;
      ocnt_q <= '0;
    end else begin
      v1_q <= fire0;
      v2_q <= v1_q;
      v3_q <= v2_q;
      if (opush) begin
        owp_q <= owp_q + OPtrW'(1);
      end
      if (opop) begin
        orp_q <= orp_q + OPtrW'(1);
      end
      ocnt_q <= ocnt_q + (OPtrW+1)'(opush) - (OPtrW+1)'(opop);
    end
  end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the staggered minmod reconstruction block.
// ----------------------------------------------------------------------------
// Small frames of cells stream in through the input queue. A model of the
// line buffers, the limited slopes and the staggered averages, kept next to
// the block, predicts every result. Each popped word is checked field by field
// against the oldest prediction. The registers are rewritten between phases,
// extremes included, and both sides idle and stall at varying rates.
// ----------------------------------------------------------------------------
module tb_top;
  import mmsr_pkg::*;

  localparam int unsigned RowCells = 1024;
  localparam int WatchdogLimit = 20000;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic                push = 1'b0;
  logic                full;
  logic signed [31:0]  cell_value_i = '0;
  logic                empty;
  logic                pop = 1'b0;
  logic signed [31:0]  half_value_o;
  logic [ColW-1:0]     out_col_o;
  logic [RowW-1:0]     out_row_o;
  logic                frame_last_o;

  minmod_staggered_reconstruction dut (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .push, .full, .cell_value_i, .empty, .pop,
    .half_value_o, .out_col_o, .out_row_o, .frame_last_o
  );

  always #4 clk_i = ~clk_i;

  // Register copies and line buffers of the prediction.
  logic [9:0]  cols_reg;
  logic [15:0] rows_reg;
  logic [17:0] alpha_reg;
  logic        parity_reg;
  logic signed [31:0] cell_rows [3*RowCells];
  logic signed [31:0] xslope_rows [2*RowCells];
  logic signed [31:0] yslope_rows [2*RowCells];
  int unsigned next_col, next_row;

  result_t averages_due[$];
  int mismatches = 0;
  int cells_sent = 0, averages_seen = 0, reg_writes = 0, lasts_seen = 0;
  int sender_idle_pct = 0, receiver_stall_pct = 0;
  int hold_request = 0;

  function automatic longint round_q16(longint x, int sh);
    return (x + (longint'(1) <<< (sh - 1))) >>> sh;
  endfunction

  function automatic logic signed [31:0] clamp32(longint x);
    if (x > 64'sd2147483647) return 32'sh7fffffff;
    if (x < -64'sd2147483648) return 32'sh80000000;
    return x[31:0];
  endfunction

  function automatic logic signed [31:0] limited_slope(logic signed [31:0] p,
                                                       logic signed [31:0] m,
                                                       logic signed [31:0] n);
    longint a = longint'(alpha_reg);
    longint f = a * (longint'(n) - longint'(m));
    longint c = (longint'(n) - longint'(p)) * 32768;
    longint b = a * (longint'(m) - longint'(p));
    longint sel = 0;
    if (f > 0 && c > 0 && b > 0) begin
      sel = f < c ? f : c;
      sel = sel < b ? sel : b;
    end else if (f < 0 && c < 0 && b < 0) begin
      sel = f > c ? f : c;
      sel = sel > b ? sel : b;
    end
    return clamp32(round_q16(sel, 16));
  endfunction

  function automatic void restart_frame();
    next_col = 0;
    next_row = 0;
  endfunction

  // Advance the prediction by one accepted cell; queues an average if due.
  function automatic void predict_cell(logic signed [31:0] v);
    int unsigned w = (cols_reg < 1 ? 1 : (cols_reg > RowCells - 4 ? RowCells - 4 : cols_reg)) + 4;
    int unsigned h = (rows_reg < 1 ? 1 : (rows_reg > 65531 ? 65531 : rows_reg)) + 4;
    int unsigned c = next_col > RowCells - 1 ? RowCells - 1 : next_col;
    int unsigned r = next_row;
    int unsigned up, md, dn, st, sb, lc, rc;
    longint sum_v, sum_s;
    result_t res;
    cell_rows[(r % 3) * RowCells + c] = v;
    if (c >= 2 && r >= 2) begin
      up = ((r - 2) % 3) * RowCells;
      md = ((r - 1) % 3) * RowCells;
      dn = (r % 3) * RowCells;
      st = ((r - 1) & 1) * RowCells + c - 1;
      xslope_rows[st] = limited_slope(cell_rows[md+c-2], cell_rows[md+c-1], cell_rows[md+c]);
      yslope_rows[st] = limited_slope(cell_rows[up+c-1], cell_rows[md+c-1], cell_rows[dn+c-1]);
    end
    if (c >= 3 && r >= 3) begin
      lc = c - 2;
      rc = c - 1;
      up = ((r - 2) % 3) * RowCells;
      md = ((r - 1) % 3) * RowCells;
      st = ((r - 2) & 1) * RowCells;
      sb = ((r - 1) & 1) * RowCells;
      sum_v = longint'(cell_rows[up+lc]) + cell_rows[up+rc] + cell_rows[md+lc]
            + cell_rows[md+rc];
      sum_s = longint'(xslope_rows[st+lc]) - xslope_rows[st+rc]
            + longint'(xslope_rows[sb+lc]) - xslope_rows[sb+rc]
            + longint'(yslope_rows[st+lc]) - yslope_rows[sb+lc]
            + longint'(yslope_rows[st+rc]) - yslope_rows[sb+rc];
      res.half_value = clamp32(round_q16(4 * sum_v + sum_s, 4));
      res.out_col = parity_reg ? lc[ColW-1:0] : rc[ColW-1:0];
      res.out_row = parity_reg ? 16'(r - 2) : 16'(r - 1);
      res.frame_last = (c + 1 >= w && r + 1 >= h);
      averages_due.push_back(res);
    end
    if (c + 1 >= w) begin
      next_col = 0;
      next_row = (r + 1 >= h) ? 0 : r + 1;
    end else begin
      next_col = c + 1;
    end
  endfunction

  task automatic wait_drained();
    while (averages_due.size() != 0) @(posedge clk_i);
  endtask

  // Writes one register once the block has gone quiet.
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [31:0] value);
    push <= 1'b0;
    wait_drained();
    repeat (8) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    reg_writes++;
    case (idx)
      RegInteriorCols:  cols_reg = value[9:0];
      RegInteriorRows:  rows_reg = value[15:0];
      RegLimiterAlpha:  alpha_reg = value[17:0];
      RegStaggerParity: parity_reg = value[0];
      default: ;
    endcase
    restart_frame();
  endtask

  task automatic set_frame(int cols, int rows, int alpha, bit parity);
    // Upper bits of the data word are junk the block has to drop.
    write_reg(RegInteriorCols, {22'($urandom_range(0, 4194303)), 10'(cols)});
    write_reg(RegInteriorRows, {16'($urandom_range(0, 65535)), 16'(rows)});
    write_reg(RegLimiterAlpha, {14'($urandom_range(0, 16383)), 18'(alpha)});
    write_reg(RegStaggerParity, {31'($urandom_range(0, 2147483647)), parity});
  endtask

  task automatic send_cell(logic signed [31:0] v);
    int gap;
    if ($urandom_range(0, 99) < sender_idle_pct) begin
      gap = $urandom_range(1, 4);
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push <= 1'b1;
    cell_value_i <= v;
    do @(posedge clk_i); while (full);
    cells_sent++;
    predict_cell(v);
  endtask

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      1: return $signed($urandom_range(0, 2000)) - 1000;
      2: return $signed($urandom_range(0, 131072)) - 65536;
      default: return $urandom();
    endcase
  endfunction

  // Result side: random pop, long hold-off on request, field checks.
  always @(posedge clk_i) begin
    result_t want;
    if (pop && !empty) begin
      averages_seen++;
      if (frame_last_o) lasts_seen++;
      if (averages_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word: value %0d col %0d row %0d",
                                       half_value_o, out_col_o, out_row_o);
      end else begin
        want = averages_due.pop_front();
        if (want.half_value !== half_value_o || want.out_col !== out_col_o ||
            want.out_row !== out_row_o || want.frame_last !== frame_last_o) begin
          mismatches++;
          if (mismatches <= 10)
            $display("word mismatch: exp value %0d col %0d row %0d last %0b, got %0d %0d %0d %0b",
                     want.half_value, want.out_col, want.out_row, want.frame_last,
                     half_value_o, out_col_o, out_row_o, frame_last_o);
        end
      end
    end
    if (hold_request > 0) begin
      hold_request <= hold_request - 1;
      pop <= 1'b0;
    end else begin
      pop <= rst_ni && ($urandom_range(0, 99) >= receiver_stall_pct);
    end
  end

  // Watchdog on cycles with no handshake of any kind.
  int quiet_cycles = 0;
  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty) || (cfg_valid_i && cfg_ready_o) || !rst_ni)
      quiet_cycles <= 0;
    else if (quiet_cycles >= WatchdogLimit) begin
      $display("watchdog expired with %0d words pending", averages_due.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else
      quiet_cycles <= quiet_cycles + 1;
  end

  task automatic test_register_extremes();
    // Width and height beyond range, then below range; partial frames only.
    set_frame(1023, 65535, 262143, 1'b0);
    repeat (6) send_cell(pick_value());
    set_frame(0, 0, 0, 1'b1);
    repeat (5) send_cell(pick_value());
  endtask

  task automatic test_directed_frame();
    // One 5x5 frame of full-scale, zero and minus-one values: saturation and frame end.
    logic signed [31:0] pat [5] = '{32'sh7fffffff, 32'sh80000000, 32'sh0,
                                    -32'sh1, 32'sh7fffffff};
    set_frame(1, 1, 262143, 1'b1);
    for (int i = 0; i < 25; i++) send_cell(pat[(i + i / 5) % 5]);
    wait_drained();
  endtask

  task automatic test_backpressure();
    set_frame(4, 6, 91750, 1'b0);
    hold_request = 300;
    repeat (60) send_cell(pick_value());
    // Sender pauses until all words are back.
    push <= 1'b0;
    wait_drained();
  endtask

  task automatic test_random_phase(int n, int idle_pct, int stall_pct);
    int sent = 0;
    int w, h, len;
    sender_idle_pct = idle_pct;
    receiver_stall_pct = stall_pct;
    while (sent < n) begin
      w = $urandom_range(0, 9) == 0 ? $urandom_range(0, 1) : $urandom_range(1, 6);
      h = $urandom_range(0, 9) == 0 ? 0 : $urandom_range(1, 4);
      set_frame(w, h, $urandom_range(0, 3) == 0 ? $urandom_range(0, 262143)
                                               : $urandom_range(32768, 131072),
                $urandom_range(0, 1));
      // One full frame and up to twelve wrapped cells of the next, within the phase's count.
      len = ((w < 1 ? 1 : w) + 4) * ((h < 1 ? 1 : h) + 4) + $urandom_range(0, 12);
      for (int k = 0; k < len && sent < n; k++) begin
        send_cell(pick_value());
        sent++;
      end
    end
    push <= 1'b0;
  endtask

  initial begin
    cols_reg = 10'd256;
    rows_reg = 16'd256;
    alpha_reg = 18'd91750;
    parity_reg = 1'b1;
    restart_frame();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_register_extremes();
    test_directed_frame();
    test_backpressure();
    test_random_phase(75, 0, 0);
    test_random_phase(75, 75, 0);
    test_random_phase(75, 0, 75);
    test_random_phase(75, 10, 10);
    wait_drained();
    repeat (20) @(posedge clk_i);
    $display("covered %0d cells, %0d averages (%0d frame ends), %0d register writes",
             cells_sent, averages_seen, lasts_seen, reg_writes);
    $display("phases: full rate, idle sender, stalled receiver, mixed, long hold-off");
    if (mismatches == 0 && averages_due.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
